@@ sv/cfs_pkg.sv @@
`default_nettype none
package cfs_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DECEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USUAL_DECEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEADWAY_TIME  = 3'd5;

	typedef struct packed {
		logic               has_leader;
		logic signed [31:0] leader_speed;
		logic        [30:0] leader_max_decel;
		logic        [30:0] leader_usual_decel;
		logic signed [31:0] own_speed;
		logic signed [31:0] gap_to_leader;
		logic               custom_valid;
		logic signed [31:0] custom_speed;
	} cfs_in_t;

	typedef struct packed {
		logic signed [31:0] follow_speed;
		logic               no_solution;
	} cfs_out_t;

	typedef struct packed {
		logic [30:0] step_interval;
		logic [30:0] max_speed;
		logic [30:0] max_decel;
		logic [30:0] usual_decel;
		logic [30:0] min_gap;
		logic [30:0] headway_time;
	} cfs_cfg_t;

endpackage
`default_nettype wire

@@ sv/car_follow_speed.sv @@
`default_nettype none
// Channel   Handshake              Payload
// input     start, busy (always 0) in_item  (cfs_in_t)
// result    done strobe, 1 cycle   out_item (cfs_out_t)
// config    cfg_we, cfg_idx        cfg_data (31 bits)
//
// A fully pipelined kernel: one item enters each cycle, and each item reaches done
// through the capture and product stages, two 97-stage divider banks each followed by
// a register stage, a 33-stage square root, two multiplier stages and the output register.
// Reset clears all valid bits and loads the register defaults. busy is tied low:
// the receiver cannot stall, so nothing ever holds the pipe.
module car_follow_speed #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire cfs_pkg::cfs_in_t   in_item,
	output logic                    done,
	output cfs_pkg::cfs_out_t       out_item,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_idx,
	input  wire logic [30:0]        cfg_data
);
	import cfs_pkg::*;

	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] WLIM = (64'sd1 <<< (61 - FRAC_BITS)) - 64'sd1;
	localparam logic signed [63:0] SENT = -64'sd100 <<< FRAC_BITS;
	localparam int unsigned NW = 96;
	localparam int unsigned DW = 64;

	cfs_cfg_t cfg_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval <= 31'd65536;
			cfg_q.max_speed     <= 31'd1092485;
			cfg_q.max_decel     <= 31'd294912;
			cfg_q.usual_decel   <= 31'd294912;
			cfg_q.min_gap       <= 31'd163840;
			cfg_q.headway_time  <= 31'd131072;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STEP_INTERVAL: cfg_q.step_interval <= cfg_data;
				REG_MAX_SPEED:     cfg_q.max_speed     <= cfg_data;
				REG_MAX_DECEL:     cfg_q.max_decel     <= cfg_data;
				REG_USUAL_DECEL:   cfg_q.usual_decel   <= cfg_data;
				REG_MIN_GAP:       cfg_q.min_gap       <= cfg_data;
				REG_HEADWAY_TIME:  cfg_q.headway_time  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	function automatic logic signed [63:0] pos31(input logic [30:0] v);
		return (v == '0) ? 64'sd1 : $signed({33'd0, v});
	endfunction

	function automatic logic signed [63:0] clampw(input logic signed [127:0] v);
		if (v > 128'(WLIM)) return WLIM;
		if (v < -128'(WLIM)) return -WLIM;
		return v[63:0];
	endfunction

	// Division by a power of two that truncates toward zero.
	function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] bias;
		bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (v + bias) >>> sh;
	endfunction

	// Leader speed plus half the closing speed, for the headway bound.
	logic signed [63:0] adh_c;
	always_comb begin
		if (in_item.own_speed > in_item.leader_speed) begin
			adh_c = 64'(in_item.leader_speed)
				+ ((64'(in_item.own_speed) - 64'(in_item.leader_speed)) >>> 1);
		end else begin
			adh_c = 64'(in_item.leader_speed);
		end
	end

	// Stage one: capture operands.
	logic v_s1;
	logic signed [63:0] vl_s1, vf_s1, gap_s1, cs_s1, t_s1, dlm_s1, dlu_s1;
	logic signed [63:0] dfm_s1, dfu_s1, mg_s1, hw_s1, ms_s1, adh_s1;
	logic lead_s1, cust_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		lead_s1 <= in_item.has_leader;
		cust_s1 <= in_item.custom_valid;
		vl_s1   <= 64'(in_item.leader_speed);
		vf_s1   <= 64'(in_item.own_speed);
		gap_s1  <= 64'(in_item.gap_to_leader);
		cs_s1   <= 64'(in_item.custom_speed);
		adh_s1  <= adh_c;
		dlm_s1  <= pos31(in_item.leader_max_decel);
		dlu_s1  <= pos31(in_item.leader_usual_decel);
		t_s1    <= pos31(cfg_q.step_interval);
		dfm_s1  <= pos31(cfg_q.max_decel);
		dfu_s1  <= pos31(cfg_q.usual_decel);
		mg_s1   <= $signed({33'd0, cfg_q.min_gap});
		hw_s1   <= $signed({33'd0, cfg_q.headway_time});
		ms_s1   <= $signed({33'd0, cfg_q.max_speed});
	end

	// Stage two: products (operands fit 33 bits, so single multipliers).
	logic v_s2;
	logic signed [63:0] vft_s2, vl2_s2, tt_s2, dlmt_s2, dlut_s2, adt_s2;
	logic signed [63:0] vl_s2, gap_s2, cs_s2, t_s2, dlm_s2, dlu_s2;
	logic signed [63:0] dfm_s2, dfu_s2, mg_s2, hw_s2, ms_s2;
	logic lead_s2, cust_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		vft_s2  <= 64'($signed(vf_s1[32:0]) * $signed(t_s1[32:0]));
		vl2_s2  <= 64'($signed(vl_s1[32:0]) * $signed(vl_s1[32:0]));
		tt_s2   <= 64'($signed(t_s1[32:0]) * $signed(t_s1[32:0]));
		dlmt_s2 <= 64'($signed(dlm_s1[32:0]) * $signed(t_s1[32:0]));
		dlut_s2 <= 64'($signed(dlu_s1[32:0]) * $signed(t_s1[32:0]));
		adt_s2  <= 64'($signed(adh_s1[32:0]) * $signed(t_s1[32:0]));
		{vl_s2, gap_s2, cs_s2, t_s2} <= {vl_s1, gap_s1, cs_s1, t_s1};
		{dlm_s2, dlu_s2, dfm_s2, dfu_s2} <= {dlm_s1, dlu_s1, dfm_s1, dfu_s1};
		{mg_s2, hw_s2, ms_s2, lead_s2, cust_s2} <= {mg_s1, hw_s1, ms_s1, lead_s1, cust_s1};
	end

	// Division bank A: quotients by variable divisors that need only stage-two
	// values: vl2/(2*dlm), vl2/(2*dlu), 2*ONE*gap/t, 2*ONE*(gap-mg)/t.
	// Quotients by powers of two are shifts and ride in the tag.
	localparam int unsigned NA = 4;
	logic signed [NW-1:0] na [NA];
	logic [DW-1:0] da [NA];
	logic signed [NW-1:0] qa [NA];
	logic va [NA];
	localparam int unsigned PW = 64 * 14 + 2;
	logic [PW-1:0] pass_in, pass_out;
	logic signed [63:0] tlat;
	logic signed [63:0] qvft_c, qdlmt_c, qdlut_c, qadt_c;

	always_comb begin
		na[0] = NW'(vl2_s2);        da[0] = DW'(2 * dlm_s2);
		na[1] = NW'(vl2_s2);        da[1] = DW'(2 * dlu_s2);
		na[2] = NW'(gap_s2) * NW'(2 * ONE);          da[2] = DW'(t_s2);
		na[3] = NW'(gap_s2 - mg_s2) * NW'(2 * ONE);  da[3] = DW'(t_s2);
		qvft_c  = shr_tz(vft_s2, FRAC_BITS + 1);
		qdlmt_c = shr_tz(dlmt_s2, FRAC_BITS);
		qdlut_c = shr_tz(dlut_s2, FRAC_BITS);
		qadt_c  = shr_tz(adt_s2, FRAC_BITS);
		pass_in = {vl_s2, gap_s2, cs_s2, t_s2, tt_s2, dfm_s2, dfu_s2,
			mg_s2, hw_s2, ms_s2, qvft_c, qdlmt_c, qdlut_c, qadt_c, lead_s2, cust_s2};
	end

	for (genvar k = 0; k < NA; k++) begin : g_da
		if (k == 0) begin : g_tag
			cfs_div #(.NW(NW), .DW(DW), .TW(PW)) u_div (
				.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .num(na[k]), .den(da[k]),
				.tag_in(pass_in), .out_valid(va[k]), .quo(qa[k]), .tag_out(pass_out));
		end else begin : g_notag
			logic unused_tag;
			cfs_div #(.NW(NW), .DW(DW), .TW(1)) u_div (
				.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .num(na[k]), .den(da[k]),
				.tag_in(1'b0), .out_valid(va[k]), .quo(qa[k]), .tag_out(unused_tag));
		end
	end

	// Stage B: c terms, headway numerator, v2 terms.
	logic v_b;
	logic signed [63:0] cs_b, t_b, tt_b, dfm_b, dfu_b, ms_b;
	logic lead_b, cust_b;
	logic signed [63:0] cm_b, cu_b, num_b, v2m_b, v2u_b, den_b;
	logic signed [63:0] vlp, gp, csp, tp, ttp, dfmp, dfup, mgp, hwp, msp;
	logic signed [63:0] qvftp, qdlmtp, qdlutp, qadtp;
	logic leadp, custp;
	logic signed [63:0] hd_c;
	always_comb begin
		{vlp, gp, csp, tp, ttp, dfmp, dfup, mgp, hwp, msp, qvftp, qdlmtp, qdlutp, qadtp,
			leadp, custp} = pass_out;
		hd_c = hwp + tp / 2;
		if (hd_c == 0) hd_c = 64'sd1;
		tlat = tp;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_b <= 1'b0;
		else         v_b <= va[0];
	end
	always_ff @(posedge clk) begin
		cm_b  <= clampw(128'(qvftp) - 128'(qa[0]) - 128'(gp));
		cu_b  <= clampw(128'(qvftp) + 128'(mgp) - 128'(qa[1]) - 128'(gp));
		num_b <= clampw(128'(gp) + 128'(qadtp) - 128'(qvftp));
		v2m_b <= 64'(2 * vlp - qdlmtp + qa[2]);
		v2u_b <= 64'(2 * vlp - qdlutp + qa[3]);
		den_b <= hd_c;
		{cs_b, t_b, tt_b, dfm_b, dfu_b} <= {csp, tlat, ttp, dfmp, dfup};
		{ms_b, lead_b, cust_b} <= {msp, leadp, custp};
	end

	// Division bank C: 2*ONE*c/df for both bounds, and the headway quotient.
	localparam int unsigned PW2 = 64 * 6 + 2;
	logic [PW2-1:0] p2_in, p2_out;
	logic signed [NW-1:0] qcm, qcu, qhw;
	logic vc, vcu_u, vch_u;
	logic unused_cu, unused_ch;
	always_comb begin
		p2_in = {v2m_b, v2u_b, cs_b, t_b, tt_b, ms_b, lead_b, cust_b};
	end
	cfs_div #(.NW(NW), .DW(DW), .TW(PW2)) u_divcm (
		.clk(clk), .arst_n(arst_n), .in_valid(v_b), .num(NW'(cm_b) * NW'(2 * ONE)),
		.den(DW'(dfm_b)), .tag_in(p2_in), .out_valid(vc), .quo(qcm), .tag_out(p2_out));
	cfs_div #(.NW(NW), .DW(DW), .TW(1)) u_divcu (
		.clk(clk), .arst_n(arst_n), .in_valid(v_b), .num(NW'(cu_b) * NW'(2 * ONE)),
		.den(DW'(dfu_b)), .tag_in(1'b0), .out_valid(vcu_u), .quo(qcu), .tag_out(unused_cu));
	cfs_div #(.NW(NW), .DW(DW), .TW(1)) u_divhw (
		.clk(clk), .arst_n(arst_n), .in_valid(v_b), .num(NW'(num_b) * NW'(ONE)),
		.den(DW'(den_b)), .tag_in(1'b0), .out_valid(vch_u), .quo(qhw), .tag_out(unused_ch));

	// Stage D: discriminants.
	logic v_d;
	logic signed [NW-1:0] discm_d, discu_d;
	logic signed [63:0] v2m_d, v2u_d, cs_d, t_d, ms_d, hwq_d, dfm_d, dfu_d;
	logic lead_d, cust_d;
	logic signed [63:0] v2mp, v2up, cs2p, t2p, tt2p, ms2p;
	logic lead2p, cust2p;
	logic signed [63:0] dfm_dl [NW+1], dfu_dl [NW+1];
	always_comb begin
		{v2mp, v2up, cs2p, t2p, tt2p, ms2p, lead2p, cust2p} = p2_out;
	end
	// Decel values delayed to meet the divider output.
	always_ff @(posedge clk) begin
		dfm_dl[0] <= dfm_b;
		dfu_dl[0] <= dfu_b;
		for (int i = 1; i < NW + 1; i++) begin
			dfm_dl[i] <= dfm_dl[i-1];
			dfu_dl[i] <= dfu_dl[i-1];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d <= 1'b0;
		else         v_d <= vc;
	end
	always_ff @(posedge clk) begin
		discm_d <= NW'(tt2p / 4) - qcm;
		discu_d <= NW'(tt2p / 4) - qcu;
		{v2m_d, v2u_d, cs_d, t_d, ms_d, lead_d, cust_d} <= {v2mp, v2up, cs2p, t2p, ms2p, lead2p, cust2p};
		hwq_d <= 64'(qhw);
		dfm_d <= dfm_dl[NW];
		dfu_d <= dfu_dl[NW];
	end

	// Square roots of both discriminants; the rest rides in a delay line.
	localparam int unsigned XW = 64;
	localparam int unsigned SL = XW / 2 + 1;
	localparam int unsigned PW3 = 64 * 7 + 4;
	logic [XW/2-1:0] rm, ru;
	logic vs, vsu_u;
	logic [PW3-1:0] p3_dl [SL];
	always_ff @(posedge clk) begin
		p3_dl[0] <= {v2m_d, v2u_d, cs_d, t_d, ms_d, hwq_d, dfm_d,
			lead_d, cust_d, discm_d[NW-1], discu_d[NW-1]};
		for (int i = 1; i < SL; i++) p3_dl[i] <= p3_dl[i-1];
	end
	logic signed [63:0] dfu3_dl [SL];
	always_ff @(posedge clk) begin
		dfu3_dl[0] <= dfu_d;
		for (int i = 1; i < SL; i++) dfu3_dl[i] <= dfu3_dl[i-1];
	end
	cfs_sqrt #(.XW(XW)) u_sqm (.clk(clk), .arst_n(arst_n), .in_valid(v_d),
		.x(discm_d[XW-1:0]), .out_valid(vs), .root(rm));
	cfs_sqrt #(.XW(XW)) u_squ (.clk(clk), .arst_n(arst_n), .in_valid(v_d),
		.x(discu_d[XW-1:0]), .out_valid(vsu_u), .root(ru));

	// Stage E: df*(root - T/2) with the wide split multiplier.
	logic signed [63:0] v2m_e, v2u_e, cs_e, t_e, ms_e, hwq_e, dfm_e;
	logic lead_e, cust_e, nm_e, nu_e;
	logic signed [127:0] pm, pu;
	logic v_e1, v_e2;
	logic [64*5+4-1:0] e_dl [2];
	always_comb begin
		{v2m_e, v2u_e, cs_e, t_e, ms_e, hwq_e, dfm_e, lead_e, cust_e, nm_e, nu_e}
			= p3_dl[SL-1];
	end
	cfs_mul u_mm (.clk(clk), .a(dfm_e), .b(64'(rm) - t_e / 2), .p(pm));
	cfs_mul u_mu (.clk(clk), .a(dfu3_dl[SL-1]), .b(64'(ru) - t_e / 2), .p(pu));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
		end else begin
			v_e1 <= vs;
			v_e2 <= v_e1;
		end
	end
	always_ff @(posedge clk) begin
		e_dl[0] <= {v2m_e, v2u_e, cs_e, ms_e, hwq_e, lead_e, cust_e, nm_e, nu_e};
		e_dl[1] <= e_dl[0];
	end

	// Stage F: scale by ONE (power of two, truncating toward zero), then min.
	// Both products fit 64 bits, so only the low word is scaled.
	logic signed [63:0] v2m_f, v2u_f, cs_f, ms_f, hwq_f;
	logic lead_f, cust_f, nm_f, nu_f;
	logic signed [127:0] v1m, v1u;
	logic signed [127:0] bm, bu, r;
	logic flag;
	always_comb begin
		{v2m_f, v2u_f, cs_f, ms_f, hwq_f, lead_f, cust_f, nm_f, nu_f} = e_dl[1];
		v1m = 128'(shr_tz(pm[63:0], FRAC_BITS));
		v1u = 128'(shr_tz(pu[63:0], FRAC_BITS));
		bm  = nm_f ? 128'(SENT) : ((v1m < 128'(v2m_f)) ? v1m : 128'(v2m_f));
		bu  = nu_f ? 128'(SENT) : ((v1u < 128'(v2u_f)) ? v1u : 128'(v2u_f));
		flag = 1'b0;
		if (!lead_f) begin
			r = cust_f ? 128'(cs_f) : 128'(ms_f);
		end else if (cust_f) begin
			r = (128'(cs_f) < bm) ? 128'(cs_f) : bm;
			flag = nm_f;
		end else begin
			r = (bu < bm) ? bu : bm;
			r = (128'(hwq_f) < r) ? 128'(hwq_f) : r;
			flag = nm_f | nu_f;
		end
	end

	// Output register with saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_e2;
	end
	always_ff @(posedge clk) begin
		if (r > 128'sd2147483647)       out_item.follow_speed <= 32'sh7FFFFFFF;
		else if (r < -128'sd2147483648) out_item.follow_speed <= 32'sh80000000;
		else                            out_item.follow_speed <= r[31:0];
		out_item.no_solution <= flag;
	end
endmodule
`default_nettype wire

@@ sv/cfs_div.sv @@
`default_nettype none
// Pipelined restoring divider: signed dividend over positive divisor, quotient
// truncated toward zero. One quotient bit per stage; a tag rides along.
module cfs_div #(
	parameter int unsigned NW = 96,
	parameter int unsigned DW = 64,
	parameter int unsigned TW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	input  wire logic        [TW-1:0] tag_in,
	output logic                      out_valid,
	output logic signed [NW-1:0]      quo,
	output logic        [TW-1:0]      tag_out
);
	logic          vld_s  [NW+1];
	logic [NW-1:0] rem_s  [NW+1];
	logic [NW-1:0] q_s    [NW+1];
	logic [DW-1:0] d_s    [NW+1];
	logic          neg_s  [NW+1];
	logic [TW-1:0] tag_s  [NW+1];

	// Stage zero takes the magnitude of the dividend.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		neg_s[0] <= num[NW-1];
		q_s[0]   <= num[NW-1] ? NW'(-num) : NW'(num);
		rem_s[0] <= '0;
		d_s[0]   <= den;
		tag_s[0] <= tag_in;
	end

	// One bit of quotient per stage, most significant first.
	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW:0] trial;
		logic [NW:0] shifted;
		always_comb begin
			shifted = {rem_s[i], q_s[i][NW-1]};
			trial   = shifted - (NW+1)'(d_s[i]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (!trial[NW]) begin
				rem_s[i+1] <= trial[NW-1:0];
				q_s[i+1]   <= {q_s[i][NW-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= shifted[NW-1:0];
				q_s[i+1]   <= {q_s[i][NW-2:0], 1'b0};
			end
			d_s[i+1]   <= d_s[i];
			neg_s[i+1] <= neg_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = neg_s[NW] ? -$signed(q_s[NW]) : $signed(q_s[NW]);
	assign tag_out   = tag_s[NW];
endmodule
`default_nettype wire

@@ sv/cfs_sqrt.sv @@
`default_nettype none
// Pipelined floor square root of a nonnegative word, one result bit per stage.
module cfs_sqrt #(
	parameter int unsigned XW = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [XW-1:0]   x,
	output logic                 out_valid,
	output logic [XW/2-1:0]      root
);
	localparam int unsigned RW = XW / 2;

	logic          vld_s [RW+1];
	logic [XW-1:0] x_s   [RW+1];
	logic [RW+1:0] r_s   [RW+1];
	logic [RW-1:0] q_s   [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		x_s[0] <= x;
		r_s[0] <= '0;
		q_s[0] <= '0;
	end

	// Digit-by-digit: bring down two bits, try 4q+1.
	for (genvar i = 0; i < RW; i++) begin : g_st
		logic [RW+3:0] rem2;
		logic [RW+3:0] trial;
		always_comb begin
			rem2  = {r_s[i], x_s[i][XW-1:XW-2]};
			trial = rem2 - {2'b00, q_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1] <= {x_s[i][XW-3:0], 2'b00};
			if (!trial[RW+3]) begin
				r_s[i+1] <= trial[RW+1:0];
				q_s[i+1] <= {q_s[i][RW-2:0], 1'b1};
			end else begin
				r_s[i+1] <= rem2[RW+1:0];
				q_s[i+1] <= {q_s[i][RW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = q_s[RW];
endmodule
`default_nettype wire

@@ sv/cfs_mul.sv @@
`default_nettype none
// Two-stage signed multiplier: 64x64 split into four 32x32 partial products.
module cfs_mul (
	input  wire logic                clk,
	input  wire logic signed [63:0]  a,
	input  wire logic signed [63:0]  b,
	output logic signed [127:0]      p
);
	logic [63:0] ll_s1, lh_s1, hl_s1;
	logic signed [63:0] hh_s1;
	logic signed [127:0] sum_s2;

	// Stage one forms the partial products.
	always_ff @(posedge clk) begin
		ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
		lh_s1 <= 64'($signed({1'b0, a[31:0]}) * $signed(b[63:32]));
		hl_s1 <= 64'($signed(a[63:32]) * $signed({1'b0, b[31:0]}));
		hh_s1 <= $signed(a[63:32]) * $signed(b[63:32]);
	end

	// Stage two adds them.
	always_ff @(posedge clk) begin
		sum_s2 <= $signed({64'd0, ll_s1}) + ($signed({{64{lh_s1[63]}}, lh_s1}) <<< 32)
			+ ($signed({{64{hl_s1[63]}}, hl_s1}) <<< 32) + ($signed({{64{hh_s1[63]}}, hh_s1}) <<< 64);
	end

	assign p = sum_s2;
endmodule
`default_nettype wire
